/* sv/tdffa_pkg.sv */
`timescale 1ns / 1ps

package tdffa_pkg;

	localparam int DEF_MAX_BLOCKS  = 256;
	localparam int DEF_OFFSET_BITS = 27;

	localparam int ADDR_W   = 32;
	localparam int SIZE_W   = 27;
	localparam int RECB_W   = 7;
	localparam int LIVE_W   = 9;
	localparam int CFG_IX_W = 2;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_SPACE  = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [CFG_IX_W-1:0] {
		CFG_POOL_BASE    = 2'd0,
		CFG_POOL_SIZE    = 2'd1,
		CFG_RECORD_BYTES = 2'd2,
		CFG_UNUSED       = 2'd3
	} cfg_ix_t;

	typedef enum logic [3:0] {
		A_IDLE,
		A_START,
		A_RD_LOWEST,
		A_WALK_FIRST,
		A_WALK,
		A_FIT,
		A_FIT_TABLE,
		A_INS1,
		A_INS2,
		A_SCAN,
		A_UNLINK,
		A_READ_SRC,
		A_MOVE1,
		A_MOVE2,
		A_DEC,
		A_CLEAR
	} act_t;

	typedef struct packed {
		act_t    act;
		logic    load_result;
		status_t res_status;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic full;
		logic empty;
		logic cur_valid;
		logic fit;
		logic table_fit;
		logic bottom_ok;
		logic match;
		logic scan_done;
		logic hit_last;
	} stat_t;

endpackage

/* sv/top_down_first_fit_heap_allocator.sv */
`timescale 1ns / 1ps
// channel | handshake            | payload
// in      | in_valid / in_stall   | operation, request_size, block_address
// out     | out_valid / out_stall | status, granted_address, live_blocks
// cfg     | cfg_we                | cfg_index, cfg_data
// allocate: a bottom check, then a list walk with one linked record read per step, then the output beat
// free: a record scan, then unlink and a move of the last record (no move if the hit is last), then the output beat
// clear and other codes: dispatch, then the output beat
// reset clears the list heads and the count; the record memories need no clearing
// one beat in flight: in_stall is high until the result beat is taken

module top_down_first_fit_heap_allocator #(
	parameter int MAX_BLOCKS  = tdffa_pkg::DEF_MAX_BLOCKS,
	parameter int OFFSET_BITS = tdffa_pkg::DEF_OFFSET_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tdffa_pkg::CFG_IX_W-1:0] cfg_index,
	input  logic [tdffa_pkg::ADDR_W-1:0]   cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     operation,
	input  logic [tdffa_pkg::SIZE_W-1:0]   request_size,
	input  logic [tdffa_pkg::ADDR_W-1:0]   block_address,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     status,
	output logic [tdffa_pkg::ADDR_W-1:0]   granted_address,
	output logic [tdffa_pkg::LIVE_W-1:0]   live_blocks
);
	import tdffa_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	tdffa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	tdffa_dp #(
		.MAX_BLOCKS  (MAX_BLOCKS),
		.OFFSET_BITS (OFFSET_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.operation       (operation),
		.request_size    (request_size),
		.block_address   (block_address),
		.cmd             (cmd),
		.stat            (stat),
		.status          (status),
		.granted_address (granted_address),
		.live_blocks     (live_blocks)
	);

endmodule

/* sv/tdffa_dp.sv */
`timescale 1ns / 1ps

module tdffa_dp #(
	parameter int MAX_BLOCKS  = tdffa_pkg::DEF_MAX_BLOCKS,
	parameter int OFFSET_BITS = tdffa_pkg::DEF_OFFSET_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [tdffa_pkg::CFG_IX_W-1:0] cfg_index,
	input  logic [tdffa_pkg::ADDR_W-1:0] cfg_data,
	input  logic [1:0]                   operation,
	input  logic [tdffa_pkg::SIZE_W-1:0] request_size,
	input  logic [tdffa_pkg::ADDR_W-1:0] block_address,
	input  tdffa_pkg::cmd_t              cmd,
	output tdffa_pkg::stat_t             stat,
	output logic [1:0]                   status,
	output logic [tdffa_pkg::ADDR_W-1:0] granted_address,
	output logic [tdffa_pkg::LIVE_W-1:0] live_blocks
);
	import tdffa_pkg::*;

	localparam int IW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int LW  = IW + 1;
	localparam int CW  = $clog2(MAX_BLOCKS + 1);
	localparam int OB  = OFFSET_BITS;
	localparam int M1  = (OB > SIZE_W) ? OB : SIZE_W;
	localparam int M2  = (M1 > CW + RECB_W + 1) ? M1 : CW + RECB_W + 1;
	localparam int AW  = M2 + 3;
	localparam logic [LW-1:0] NULL_LINK = {1'b1, {IW{1'b0}}};

	logic [OB-1:0] start_mem [MAX_BLOCKS];
	logic [OB-1:0] len_mem   [MAX_BLOCKS];
	logic [LW-1:0] lower_mem [MAX_BLOCKS];
	logic [LW-1:0] upper_mem [MAX_BLOCKS];

	logic [ADDR_W-1:0] pool_base_q;
	logic [SIZE_W-1:0] pool_size_q;
	logic [RECB_W-1:0] rec_bytes_q;

	logic [CW-1:0] count_q;
	logic [LW-1:0] lowest_q, highest_q;
	op_t           op_q;
	logic [SIZE_W-1:0] size_q;
	logic [ADDR_W-1:0] addr_q;
	logic signed [AW-1:0] end_q, tend_q, off_q;
	logic [CW-1:0] scan_q;
	logic [LW-1:0] below_q, above_q;
	logic [IW-1:0] hit_q;

	logic [OB-1:0] rd_start, rd_len;
	logic [LW-1:0] rd_lower, rd_upper, rd_idx_q;

	logic [LW-1:0] raddr;
	logic [IW-1:0] new_idx, last_idx;
	logic [LW-1:0] new_link, hit_link;
	logic signed [AW-1:0] rs_w, rl_w, size_w, psize_w, bot_w, gap_w, tgap_w, tend_w;
	logic [ADDR_W:0] match_sum;

	logic          sl_we;
	logic [IW-1:0] sl_wa;
	logic [OB-1:0] s_wd, l_wd;
	logic          lo_we, up_we;
	logic [IW-1:0] lo_wa, up_wa;
	logic [LW-1:0] lo_wd, up_wd;

	assign new_idx  = count_q[IW-1:0];
	assign last_idx = IW'(count_q - CW'(1));
	assign new_link = {1'b0, new_idx};
	assign hit_link = {1'b0, hit_q};

	assign rs_w    = signed'(AW'(rd_start));
	assign rl_w    = signed'(AW'(rd_len));
	assign size_w  = signed'(AW'(size_q));
	assign psize_w = signed'(AW'(pool_size_q));
	assign gap_w   = end_q - rs_w - rl_w;
	assign tgap_w  = end_q - tend_q;
	assign bot_w   = lowest_q[IW] ? psize_w : rs_w;
	assign tend_w  = signed'((AW'(count_q) + AW'(1)) * AW'(rec_bytes_q));
	assign match_sum = (ADDR_W + 1)'(pool_base_q) + (ADDR_W + 1)'(rd_start);

	assign stat.op        = op_q;
	assign stat.full      = (count_q == CW'(MAX_BLOCKS));
	assign stat.empty     = (count_q == '0);
	assign stat.cur_valid = !rd_idx_q[IW];
	assign stat.fit       = (gap_w >= size_w);
	assign stat.table_fit = (tgap_w >= size_w);
	assign stat.bottom_ok = (bot_w >= tend_q);
	assign stat.match     = (match_sum[ADDR_W-1:0] == addr_q);
	assign stat.scan_done = (scan_q == count_q);
	assign stat.hit_last  = (hit_q == last_idx);

	always_comb begin
		case (cmd.act)
			A_RD_LOWEST:  raddr = lowest_q;
			A_WALK_FIRST: raddr = highest_q;
			A_WALK:       raddr = rd_lower;
			A_SCAN:       raddr = {1'b0, scan_q[IW-1:0]};
			A_READ_SRC:   raddr = {1'b0, last_idx};
			default:      raddr = rd_idx_q;
		endcase
	end

	always_comb begin
		sl_we = 1'b0;
		sl_wa = new_idx;
		s_wd  = OB'(off_q);
		l_wd  = OB'(size_q);
		lo_we = 1'b0;
		lo_wa = above_q[IW-1:0];
		lo_wd = new_link;
		up_we = 1'b0;
		up_wa = below_q[IW-1:0];
		up_wd = new_link;
		case (cmd.act)
			A_INS1: begin
				sl_we = 1'b1;
				lo_we = !above_q[IW];
				up_we = !below_q[IW];
			end
			A_INS2: begin
				lo_we = 1'b1;
				lo_wa = new_idx;
				lo_wd = below_q;
				up_we = 1'b1;
				up_wa = new_idx;
				up_wd = above_q;
			end
			A_UNLINK: begin
				lo_we = !rd_upper[IW];
				lo_wa = rd_upper[IW-1:0];
				lo_wd = rd_lower;
				up_we = !rd_lower[IW];
				up_wa = rd_lower[IW-1:0];
				up_wd = rd_upper;
			end
			A_MOVE1: begin
				sl_we = 1'b1;
				sl_wa = hit_q;
				s_wd  = rd_start;
				l_wd  = rd_len;
				lo_we = !rd_upper[IW];
				lo_wa = rd_upper[IW-1:0];
				lo_wd = hit_link;
				up_we = !rd_lower[IW];
				up_wa = rd_lower[IW-1:0];
				up_wd = hit_link;
			end
			A_MOVE2: begin
				lo_we = 1'b1;
				lo_wa = hit_q;
				lo_wd = below_q;
				up_we = 1'b1;
				up_wa = hit_q;
				up_wd = above_q;
			end
			default: begin
				sl_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (sl_we) begin
			start_mem[sl_wa] <= s_wd;
			len_mem[sl_wa]   <= l_wd;
		end
		if (lo_we)
			lower_mem[lo_wa] <= lo_wd;
		if (up_we)
			upper_mem[up_wa] <= up_wd;
		rd_start <= start_mem[raddr[IW-1:0]];
		rd_len   <= len_mem[raddr[IW-1:0]];
		rd_lower <= lower_mem[raddr[IW-1:0]];
		rd_upper <= upper_mem[raddr[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q <= '0;
			pool_size_q <= '0;
			rec_bytes_q <= RECB_W'(24);
			count_q     <= '0;
			lowest_q    <= NULL_LINK;
			highest_q   <= NULL_LINK;
			rd_idx_q    <= NULL_LINK;
			scan_q      <= '0;
		end else begin
			rd_idx_q <= raddr;
			if (cfg_we) begin
				case (cfg_ix_t'(cfg_index))
					CFG_POOL_BASE:    pool_base_q <= cfg_data;
					CFG_POOL_SIZE:    pool_size_q <= cfg_data[SIZE_W-1:0];
					CFG_RECORD_BYTES: rec_bytes_q <= cfg_data[RECB_W-1:0];
					default:          rec_bytes_q <= rec_bytes_q;
				endcase
			end
			case (cmd.act)
				A_START: scan_q <= '0;
				A_SCAN:  scan_q <= scan_q + CW'(1);
				A_INS1: begin
					if (below_q[IW])
						lowest_q <= new_link;
					if (above_q[IW])
						highest_q <= new_link;
				end
				A_INS2:  count_q <= count_q + CW'(1);
				A_UNLINK: begin
					if (lowest_q == rd_idx_q)
						lowest_q <= rd_upper;
					if (highest_q == rd_idx_q)
						highest_q <= rd_lower;
				end
				A_MOVE1: begin
					if (lowest_q == rd_idx_q)
						lowest_q <= hit_link;
					if (highest_q == rd_idx_q)
						highest_q <= hit_link;
				end
				A_MOVE2: count_q <= count_q - CW'(1);
				A_DEC:   count_q <= count_q - CW'(1);
				A_CLEAR: begin
					count_q   <= '0;
					lowest_q  <= NULL_LINK;
					highest_q <= NULL_LINK;
				end
				default: scan_q <= scan_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.act)
			A_START: begin
				op_q   <= op_t'(operation);
				size_q <= request_size;
				addr_q <= block_address;
				end_q  <= psize_w;
				tend_q <= tend_w;
			end
			A_WALK: end_q <= rs_w;
			A_FIT: begin
				below_q <= rd_idx_q;
				above_q <= rd_upper;
				off_q   <= end_q - size_w;
			end
			A_FIT_TABLE: begin
				below_q <= NULL_LINK;
				above_q <= lowest_q;
				off_q   <= end_q - size_w;
			end
			A_UNLINK: hit_q <= rd_idx_q[IW-1:0];
			A_MOVE1: begin
				below_q <= rd_lower;
				above_q <= rd_upper;
			end
			default: hit_q <= hit_q;
		endcase
		if (cmd.load_result) begin
			status      <= cmd.res_status;
			live_blocks <= LIVE_W'(count_q);
			if (cmd.res_status == ST_OK && op_q == OP_ALLOC)
				granted_address <= pool_base_q + ADDR_W'(off_q);
			else
				granted_address <= '0;
		end
	end

endmodule

/* sv/tdffa_ctrl.sv */
`timescale 1ns / 1ps

module tdffa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  tdffa_pkg::stat_t stat,
	output tdffa_pkg::cmd_t  cmd
);
	import tdffa_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_CHK_BOTTOM,
		S_WALK,
		S_INS1,
		S_INS2,
		S_SCAN,
		S_RDSRC,
		S_MOVE1,
		S_MOVE2,
		S_REPORT,
		S_OUT
	} state_t;

	state_t  state_q, state_d;
	status_t res_q, res_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d         = state_q;
		res_d           = res_q;
		cmd.act         = A_IDLE;
		cmd.load_result = 1'b0;
		cmd.res_status  = res_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.act = A_START;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				res_d   = ST_OK;
				state_d = S_REPORT;
				case (stat.op)
					OP_ALLOC: begin
						if (stat.full) begin
							res_d = ST_FULL;
						end else begin
							cmd.act = A_RD_LOWEST;
							state_d = S_CHK_BOTTOM;
						end
					end
					OP_FREE: begin
						if (stat.empty) begin
							res_d = ST_NOT_FOUND;
						end else begin
							cmd.act = A_SCAN;
							state_d = S_SCAN;
						end
					end
					OP_CLEAR: cmd.act = A_CLEAR;
					default:  res_d = ST_OK;
				endcase
			end
			S_CHK_BOTTOM: begin
				if (stat.bottom_ok) begin
					cmd.act = A_WALK_FIRST;
					state_d = S_WALK;
				end else begin
					res_d   = ST_NO_SPACE;
					state_d = S_REPORT;
				end
			end
			S_WALK: begin
				if (stat.cur_valid) begin
					if (stat.fit) begin
						cmd.act = A_FIT;
						state_d = S_INS1;
					end else begin
						cmd.act = A_WALK;
					end
				end else if (stat.table_fit) begin
					cmd.act = A_FIT_TABLE;
					state_d = S_INS1;
				end else begin
					res_d   = ST_NO_SPACE;
					state_d = S_REPORT;
				end
			end
			S_INS1: begin
				cmd.act = A_INS1;
				state_d = S_INS2;
			end
			S_INS2: begin
				cmd.act = A_INS2;
				res_d   = ST_OK;
				state_d = S_REPORT;
			end
			S_SCAN: begin
				if (stat.match) begin
					cmd.act = A_UNLINK;
					state_d = S_RDSRC;
				end else if (stat.scan_done) begin
					res_d   = ST_NOT_FOUND;
					state_d = S_REPORT;
				end else begin
					cmd.act = A_SCAN;
				end
			end
			S_RDSRC: begin
				res_d = ST_OK;
				if (stat.hit_last) begin
					cmd.act = A_DEC;
					state_d = S_REPORT;
				end else begin
					cmd.act = A_READ_SRC;
					state_d = S_MOVE1;
				end
			end
			S_MOVE1: begin
				cmd.act = A_MOVE1;
				state_d = S_MOVE2;
			end
			S_MOVE2: begin
				cmd.act = A_MOVE2;
				state_d = S_REPORT;
			end
			S_REPORT: begin
				cmd.load_result = 1'b1;
				state_d         = S_OUT;
			end
			S_OUT: begin
				if (!out_stall)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			res_q     <= ST_OK;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			if (state_q == S_REPORT)
				out_valid <= 1'b1;
			else if (state_q == S_OUT && !out_stall)
				out_valid <= 1'b0;
		end
	end

endmodule
